[rtl/pidc_pkg.sv]
`timescale 1ns / 1ps

package pidc_pkg;

    localparam int DEF_DATA_WIDTH     = 16;
    localparam int DEF_GAIN_WIDTH     = 24;
    localparam int DEF_GAIN_FRAC_BITS = 12;
    localparam int DEF_SUM_WIDTH      = 40;

    localparam int CFG_INDEX_WIDTH = 3;

    typedef enum logic [CFG_INDEX_WIDTH-1:0] {
        REG_PROP_GAIN      = 3'd0,
        REG_INTEGRAL_GAIN  = 3'd1,
        REG_DERIV_GAIN     = 3'd2,
        REG_BIAS_OFFSET    = 3'd3,
        REG_INTEGRAL_LIMIT = 3'd4,
        REG_OUTPUT_LIMIT   = 3'd5
    } t_reg_index;

    localparam logic KIND_SAMPLE  = 1'b0;
    localparam logic KIND_RESTART = 1'b1;

endpackage

[rtl/pidc_in_if.sv]
`timescale 1ns / 1ps

interface pidc_in_if import pidc_pkg::*; #(
    parameter int DATA_WIDTH = DEF_DATA_WIDTH
) ();
    logic                         valid;
    logic                         ready;
    logic                         kind;
    logic signed [DATA_WIDTH-1:0] setpoint;
    logic signed [DATA_WIDTH-1:0] measurement;

    modport source (output valid, kind, setpoint, measurement, input ready);
    modport sink   (input valid, kind, setpoint, measurement, output ready);
endinterface

[rtl/pidc_out_if.sv]
`timescale 1ns / 1ps

interface pidc_out_if import pidc_pkg::*; #(
    parameter int DATA_WIDTH = DEF_DATA_WIDTH
) ();
    logic                         valid;
    logic                         ready;
    logic signed [DATA_WIDTH-1:0] drive;

    modport source (output valid, drive, input ready);
    modport sink   (input valid, drive, output ready);
endinterface

[rtl/pidc_cfg_if.sv]
`timescale 1ns / 1ps

interface pidc_cfg_if import pidc_pkg::*; #(
    parameter int CFG_DATA_WIDTH = DEF_GAIN_WIDTH
) ();
    logic                       valid;
    logic                       ready;
    logic [CFG_INDEX_WIDTH-1:0] index;
    logic [CFG_DATA_WIDTH-1:0]  data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

[rtl/pidc_sat.sv]
`timescale 1ns / 1ps

module pidc_sat import pidc_pkg::*; #(
    parameter int IN_WIDTH  = 2 * DEF_DATA_WIDTH,
    parameter int LIM_WIDTH = DEF_DATA_WIDTH - 1
) (
    input  logic signed [IN_WIDTH-1:0]  i_value,
    input  logic        [LIM_WIDTH-1:0] i_limit,
    output logic signed [LIM_WIDTH:0]   o_value
);

    logic signed [IN_WIDTH-1:0] lim_pos;
    logic signed [IN_WIDTH-1:0] lim_neg;

    assign lim_pos = $signed(IN_WIDTH'(i_limit));
    assign lim_neg = -lim_pos;

    always_comb begin
        if (i_value > lim_pos) begin
            o_value = lim_pos[LIM_WIDTH:0];
        end else if (i_value < lim_neg) begin
            o_value = lim_neg[LIM_WIDTH:0];
        end else begin
            o_value = i_value[LIM_WIDTH:0];
        end
    end

endmodule

[rtl/pid_controller_step.sv]
`timescale 1ns / 1ps

// Fixed-point PID controller. Each sample item yields one drive value; a new item
// is taken every cycle while the output is not stalled by o_out.ready. The only
// recurrence is the error accumulator and previous-sample update, done in one
// stage, and the multiplies and clamps sit in the registered stages behind it.
// A restart item clears the controller state and yields no item. Gains are
// signed Q12.12; the integral product is formed from two partial products.
module pid_controller_step import pidc_pkg::*; #(
    parameter int DATA_WIDTH     = DEF_DATA_WIDTH,
    parameter int GAIN_WIDTH     = DEF_GAIN_WIDTH,
    parameter int GAIN_FRAC_BITS = DEF_GAIN_FRAC_BITS,
    parameter int SUM_WIDTH      = DEF_SUM_WIDTH
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    pidc_in_if.sink    i_in,
    pidc_out_if.source o_out,
    pidc_cfg_if.sink   i_cfg
);

    localparam int LIM_W = DATA_WIDTH - 1;
    localparam int ERR_W = DATA_WIDTH + 1;
    localparam int E2_W  = DATA_WIDTH + 2;
    localparam int SW1   = SUM_WIDTH + 1;
    localparam int PW    = GAIN_WIDTH + ERR_W;
    localparam int PD_W  = PW + 1;
    localparam int LO_W  = SUM_WIDTH / 2;
    localparam int HI_W  = SUM_WIDTH - LO_W;
    localparam int LOP_W = GAIN_WIDTH + LO_W + 1;
    localparam int HIP_W = GAIN_WIDTH + HI_W;
    localparam int IP_W  = GAIN_WIDTH + SUM_WIDTH;
    localparam int TW    = PW + 2;

    // Configuration registers
    logic signed [GAIN_WIDTH-1:0] r_prop_gain;
    logic signed [GAIN_WIDTH-1:0] r_int_gain;
    logic signed [GAIN_WIDTH-1:0] r_deriv_gain;
    logic        [LIM_W-1:0]      r_bias_offset;
    logic        [LIM_W-1:0]      r_integral_limit;
    logic        [LIM_W-1:0]      r_output_limit;

    // Controller state
    logic                         r_primed;
    logic signed [DATA_WIDTH-1:0] r_prev_meas;
    logic signed [ERR_W-1:0]      r_prev_err;
    logic signed [SUM_WIDTH-1:0]  r_sum;

    // Pipeline
    logic r_v0, r_v1, r_v2, r_v3, r_v4, r_v5, r_ov;
    logic ld0, ld1, ld2, ld3, ld4, ld5, ld_out;
    logic adv0;

    logic                         r_s0_kind;
    logic signed [DATA_WIDTH-1:0] r_s0_sp;
    logic signed [DATA_WIDTH-1:0] r_s0_meas;

    logic signed [ERR_W-1:0]     r_s1_err;
    logic signed [ERR_W-1:0]     r_s1_dm;
    logic signed [SUM_WIDTH-1:0] r_s1_sum;

    logic signed [PW-1:0]    r_s2_p;
    logic signed [PW-1:0]    r_s2_d;
    logic signed [LOP_W-1:0] r_s2_ilo;
    logic signed [HIP_W-1:0] r_s2_ihi;

    logic signed [PW-1:0]   r_s3_p;
    logic signed [PW-1:0]   r_s3_d;
    logic signed [IP_W-1:0] r_s3_ifull;

    logic signed [PD_W-1:0]       r_s4_pd;
    logic signed [DATA_WIDTH-1:0] r_s4_iterm;

    logic signed [TW-1:0] r_s5_total;

    logic signed [DATA_WIDTH-1:0] r_out_drive;

    logic signed [ERR_W-1:0]      n_err;
    logic signed [ERR_W-1:0]      n_dm;
    logic signed [E2_W-1:0]       n_e2;
    logic signed [SW1-1:0]        n_sum_wide;
    logic signed [SUM_WIDTH-1:0]  n_sum;
    logic signed [PW-1:0]         n_p;
    logic signed [PW-1:0]         n_d;
    logic signed [LOP_W-1:0]      n_ilo;
    logic signed [HIP_W-1:0]      n_ihi;
    logic signed [IP_W-1:0]       n_ifull;
    logic signed [IP_W-1:0]       n_ishift;
    logic signed [DATA_WIDTH-1:0] n_iterm;
    logic signed [TW-1:0]         n_biased;
    logic signed [DATA_WIDTH-1:0] n_drive;

    // Each stage loads when it is empty or its item moves on.
    assign ld_out = !r_ov || o_out.ready;
    assign ld5    = !r_v5 || ld_out;
    assign ld4    = !r_v4 || ld5;
    assign ld3    = !r_v3 || ld4;
    assign ld2    = !r_v2 || ld3;
    assign ld1    = !r_v1 || ld2;
    assign ld0    = !r_v0 || ld1;
    assign adv0   = r_v0 && ld1;

    assign i_in.ready  = ld0;
    assign i_cfg.ready = 1'b1;
    assign o_out.valid = r_ov;
    assign o_out.drive = r_out_drive;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prop_gain      <= '0;
            r_int_gain       <= '0;
            r_deriv_gain     <= '0;
            r_bias_offset    <= '0;
            r_integral_limit <= '1;
            r_output_limit   <= '1;
        end else if (i_cfg.valid) begin
            case (t_reg_index'(i_cfg.index))
                REG_PROP_GAIN:      r_prop_gain      <= i_cfg.data[GAIN_WIDTH-1:0];
                REG_INTEGRAL_GAIN:  r_int_gain       <= i_cfg.data[GAIN_WIDTH-1:0];
                REG_DERIV_GAIN:     r_deriv_gain     <= i_cfg.data[GAIN_WIDTH-1:0];
                REG_BIAS_OFFSET:    r_bias_offset    <= i_cfg.data[LIM_W-1:0];
                REG_INTEGRAL_LIMIT: r_integral_limit <= i_cfg.data[LIM_W-1:0];
                REG_OUTPUT_LIMIT:   r_output_limit   <= i_cfg.data[LIM_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // Error, measurement change and saturating trapezoidal sum
    always_comb begin
        n_err      = ERR_W'(r_s0_sp) - ERR_W'(r_s0_meas);
        n_dm       = r_primed ? (ERR_W'(r_prev_meas) - ERR_W'(r_s0_meas)) : '0;
        n_e2       = E2_W'(n_err) + E2_W'(r_prev_err);
        n_sum_wide = SW1'(r_sum) + SW1'(n_e2);
        if (n_sum_wide[SW1-1] != n_sum_wide[SW1-2]) begin
            n_sum = {n_sum_wide[SW1-1], {(SUM_WIDTH-1){!n_sum_wide[SW1-1]}}};
        end else begin
            n_sum = n_sum_wide[SUM_WIDTH-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_primed    <= 1'b0;
            r_prev_meas <= '0;
            r_prev_err  <= '0;
            r_sum       <= '0;
        end else if (adv0) begin
            if (r_s0_kind == KIND_RESTART) begin
                r_primed   <= 1'b0;
                r_prev_err <= '0;
                r_sum      <= '0;
            end else begin
                r_primed    <= 1'b1;
                r_prev_meas <= r_s0_meas;
                r_prev_err  <= n_err;
                r_sum       <= n_sum;
            end
        end
    end

    always_comb begin
        n_p     = PW'(r_prop_gain) * PW'(r_s1_err);
        n_d     = PW'(r_deriv_gain) * PW'(r_s1_dm);
        n_ilo   = LOP_W'(r_int_gain) * LOP_W'($signed({1'b0, r_s1_sum[LO_W-1:0]}));
        n_ihi   = HIP_W'(r_int_gain) * HIP_W'($signed(r_s1_sum[SUM_WIDTH-1:LO_W]));
        n_ifull = (IP_W'(r_s2_ihi) <<< LO_W) + IP_W'(r_s2_ilo);
        n_ishift = r_s3_ifull >>> (GAIN_FRAC_BITS + 1);
        if (r_s5_total == '0) begin
            n_biased = '0;
        end else if (r_s5_total[TW-1]) begin
            n_biased = r_s5_total - TW'($signed({1'b0, r_bias_offset}));
        end else begin
            n_biased = r_s5_total + TW'($signed({1'b0, r_bias_offset}));
        end
    end

    pidc_sat #(
        .IN_WIDTH  (IP_W),
        .LIM_WIDTH (LIM_W)
    ) u_int_sat (
        .i_value (n_ishift),
        .i_limit (r_integral_limit),
        .o_value (n_iterm)
    );

    pidc_sat #(
        .IN_WIDTH  (TW),
        .LIM_WIDTH (LIM_W)
    ) u_out_sat (
        .i_value (n_biased),
        .i_limit (r_output_limit),
        .o_value (n_drive)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v0 <= 1'b0;
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
            r_v5 <= 1'b0;
            r_ov <= 1'b0;
        end else begin
            if (ld0) begin
                r_v0 <= i_in.valid;
            end
            if (ld1) begin
                r_v1 <= r_v0 && (r_s0_kind == KIND_SAMPLE);
            end
            if (ld2) begin
                r_v2 <= r_v1;
            end
            if (ld3) begin
                r_v3 <= r_v2;
            end
            if (ld4) begin
                r_v4 <= r_v3;
            end
            if (ld5) begin
                r_v5 <= r_v4;
            end
            if (ld_out) begin
                r_ov <= r_v5;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (ld0) begin
            r_s0_kind <= i_in.kind;
            r_s0_sp   <= i_in.setpoint;
            r_s0_meas <= i_in.measurement;
        end
        if (ld1) begin
            r_s1_err <= n_err;
            r_s1_dm  <= n_dm;
            r_s1_sum <= n_sum;
        end
        if (ld2) begin
            r_s2_p   <= n_p;
            r_s2_d   <= n_d;
            r_s2_ilo <= n_ilo;
            r_s2_ihi <= n_ihi;
        end
        if (ld3) begin
            r_s3_p     <= r_s2_p >>> GAIN_FRAC_BITS;
            r_s3_d     <= r_s2_d >>> GAIN_FRAC_BITS;
            r_s3_ifull <= n_ifull;
        end
        if (ld4) begin
            r_s4_pd    <= PD_W'(r_s3_p) + PD_W'(r_s3_d);
            r_s4_iterm <= n_iterm;
        end
        if (ld5) begin
            r_s5_total <= TW'(r_s4_pd) + TW'(r_s4_iterm);
        end
        if (ld_out) begin
            r_out_drive <= n_drive;
        end
    end

endmodule

[tb/tb_top.sv]
`timescale 1ns / 1ps

module tb_top;
    import pidc_pkg::*;

    localparam int DW             = DEF_DATA_WIDTH;
    localparam int GW             = DEF_GAIN_WIDTH;
    localparam int LW             = DEF_DATA_WIDTH - 1;
    localparam int WATCHDOG_LIMIT = 10000;
    localparam int DRAIN_CYCLES   = 20;
    localparam int PHASES         = 8;
    localparam int PHASE_ITEMS    = 222;

    class drive_predictor;
        logic signed [GW-1:0]  prop_gain;
        logic signed [GW-1:0]  integral_gain;
        logic signed [GW-1:0]  deriv_gain;
        logic [LW-1:0]         bias_offset;
        logic [LW-1:0]         integral_limit;
        logic [LW-1:0]         output_limit;
        bit                    primed;
        logic signed [DW-1:0]  prev_meas;
        logic signed [DW:0]    prev_err;
        logic signed [DEF_SUM_WIDTH-1:0] doubled_sum;
        logic signed [DW-1:0]  pending_drives[$];
        int                    mismatches;

        function new();
            prop_gain      = '0;
            integral_gain  = '0;
            deriv_gain     = '0;
            bias_offset    = '0;
            integral_limit = '1;
            output_limit   = '1;
            primed         = 1'b0;
            prev_meas      = '0;
            prev_err       = '0;
            doubled_sum    = '0;
            mismatches     = 0;
        endfunction

        function longint clamp_sym(longint v, logic [LW-1:0] lim);
            longint l;
            l = longint'(lim);
            if (v > l) return l;
            if (v < -l) return -l;
            return v;
        endfunction

        function void set_register(logic [CFG_INDEX_WIDTH-1:0] idx, logic [GW-1:0] data);
            case (idx)
                REG_PROP_GAIN:      prop_gain      = data;
                REG_INTEGRAL_GAIN:  integral_gain  = data;
                REG_DERIV_GAIN:     deriv_gain     = data;
                REG_BIAS_OFFSET:    bias_offset    = data[LW-1:0];
                REG_INTEGRAL_LIMIT: integral_limit = data[LW-1:0];
                REG_OUTPUT_LIMIT:   output_limit   = data[LW-1:0];
                default: ;
            endcase
        endfunction

        function void take_item(logic kind, logic signed [DW-1:0] sp,
                                logic signed [DW-1:0] meas);
            longint err, e2, s, p_term, d_term, i_term, total;
            longint sum_max, sum_min;
            if (kind == KIND_RESTART) begin
                primed      = 1'b0;
                prev_err    = '0;
                doubled_sum = '0;
                return;
            end
            sum_max = (longint'(1) <<< (DEF_SUM_WIDTH - 1)) - 1;
            sum_min = -sum_max - 1;
            err = longint'(sp) - longint'(meas);
            if (primed) begin
                d_term = (longint'(deriv_gain) * (longint'(prev_meas) - longint'(meas)))
                         >>> DEF_GAIN_FRAC_BITS;
            end else begin
                d_term = 0;
            end
            primed    = 1'b1;
            prev_meas = meas;
            e2 = err + longint'(prev_err);
            s  = longint'(doubled_sum) + e2;
            if (s > sum_max) s = sum_max;
            if (s < sum_min) s = sum_min;
            doubled_sum = s[DEF_SUM_WIDTH-1:0];
            prev_err    = err[DW:0];
            p_term = (longint'(prop_gain) * err) >>> DEF_GAIN_FRAC_BITS;
            i_term = clamp_sym((longint'(integral_gain) * longint'(doubled_sum))
                               >>> (DEF_GAIN_FRAC_BITS + 1), integral_limit);
            total = p_term + d_term + i_term;
            if (total > 0) total = total + longint'(bias_offset);
            else if (total < 0) total = total - longint'(bias_offset);
            total = clamp_sym(total, output_limit);
            pending_drives.push_back(total[DW-1:0]);
        endfunction

        function void check_drive(logic signed [DW-1:0] got);
            logic signed [DW-1:0] want;
            if (pending_drives.size() == 0) begin
                $display("%0t: unexpected drive item, expected none, actual %0d", $time, got);
                mismatches++;
                return;
            end
            want = pending_drives.pop_front();
            if (got !== want) begin
                $display("%0t: drive mismatch, expected %0d, actual %0d", $time, want, got);
                mismatches++;
            end
        endfunction
    endclass

    logic clk;
    logic rst_n;
    bit   throttle;
    int   quiet_cycles;
    logic signed [DW-1:0] last_sp;
    logic signed [DW-1:0] last_meas;

    pidc_in_if  in_if ();
    pidc_out_if out_if ();
    pidc_cfg_if cfg_if ();

    drive_predictor tracker = new();

    pid_controller_step dut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_in    (in_if),
        .o_out   (out_if),
        .i_cfg   (cfg_if)
    );

    always begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    always @(posedge clk) begin
        if (rst_n) begin
            if (in_if.valid && in_if.ready) begin
                tracker.take_item(in_if.kind, in_if.setpoint, in_if.measurement);
            end
            if (out_if.valid && out_if.ready) begin
                tracker.check_drive(out_if.drive);
            end
            if (cfg_if.valid && cfg_if.ready) begin
                tracker.set_register(cfg_if.index, cfg_if.data);
            end
            if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready) ||
                (cfg_if.valid && cfg_if.ready)) begin
                quiet_cycles <= 0;
            end else begin
                quiet_cycles <= quiet_cycles + 1;
            end
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("pid_controller_step test failed");
                $finish;
            end
        end
    end

    initial begin
        out_if.ready = 1'b0;
        forever begin
            @(negedge clk);
            out_if.ready <= !(throttle && $urandom_range(0, 99) < 11);
        end
    end

    task automatic send_item(input logic kind, input logic [DW-1:0] sp,
                             input logic [DW-1:0] meas);
        while (throttle && $urandom_range(0, 99) < 11) begin
            in_if.valid <= 1'b0;
            @(negedge clk);
        end
        in_if.valid       <= 1'b1;
        in_if.kind        <= kind;
        in_if.setpoint    <= sp;
        in_if.measurement <= meas;
        do @(posedge clk); while (!in_if.ready);
        @(negedge clk);
    endtask

    task automatic stop_items();
        in_if.valid <= 1'b0;
        do @(negedge clk); while (tracker.pending_drives.size() != 0);
    endtask

    task automatic settle();
        stop_items();
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    task automatic write_reg(input logic [CFG_INDEX_WIDTH-1:0] idx, input logic [GW-1:0] data);
        cfg_if.valid <= 1'b1;
        cfg_if.index <= idx;
        cfg_if.data  <= data;
        do @(posedge clk); while (!cfg_if.ready);
        @(negedge clk);
    endtask

    task automatic apply_setting(input logic [GW-1:0] pg, input logic [GW-1:0] ig,
                                 input logic [GW-1:0] dg, input logic [GW-1:0] bias,
                                 input logic [GW-1:0] ilim, input logic [GW-1:0] olim);
        write_reg(REG_PROP_GAIN, pg);
        write_reg(REG_INTEGRAL_GAIN, ig);
        write_reg(REG_DERIV_GAIN, dg);
        write_reg(REG_BIAS_OFFSET, bias);
        write_reg(REG_INTEGRAL_LIMIT, ilim);
        write_reg(REG_OUTPUT_LIMIT, olim);
        write_reg(CFG_INDEX_WIDTH'(int'(REG_OUTPUT_LIMIT) + 1 + $urandom_range(0, 1)),
                  GW'($urandom));
        cfg_if.valid <= 1'b0;
    endtask

    function automatic logic [GW-1:0] pick_gain();
        logic [GW-1:0] g;
        case ($urandom_range(0, 5))
            0:       g = GW'($signed($urandom_range(0, 32768)) - 16384);
            1:       g = GW'($signed($urandom_range(0, 4096)) - 2048);
            2:       g = GW'($urandom);
            3:       g = {1'b0, {(GW-1){1'b1}}};
            4:       g = {1'b1, {(GW-1){1'b0}}};
            default: g = '0;
        endcase
        return g;
    endfunction

    function automatic logic [GW-1:0] pick_limit();
        case ($urandom_range(0, 4))
            0:       return '0;
            1:       return GW'({LW{1'b1}});
            2:       return GW'($urandom_range(0, 255));
            default: return GW'($urandom);
        endcase
    endfunction

    task automatic send_random_item();
        logic [DW-1:0] sp, meas;
        int r;
        r = $urandom_range(0, 99);
        if (r < 5) begin
            send_item(KIND_RESTART, DW'($urandom), DW'($urandom));
            return;
        end
        if (r < 60) begin
            sp   = DW'($urandom);
            meas = DW'($urandom);
        end else if (r < 85) begin
            sp   = ($urandom_range(0, 9) == 0) ? DW'($urandom) : last_sp;
            meas = last_meas + DW'($signed($urandom_range(0, 512)) - 256);
        end else if (r < 95) begin
            case ($urandom_range(0, 3))
                0:       sp = {1'b0, {(DW-1){1'b1}}};
                1:       sp = {1'b1, {(DW-1){1'b0}}};
                2:       sp = '0;
                default: sp = '1;
            endcase
            meas = ~sp;
        end else begin
            sp   = DW'($urandom);
            meas = sp;
        end
        last_sp   = sp;
        last_meas = meas;
        send_item(KIND_SAMPLE, sp, meas);
    endtask

    initial begin
        rst_n              = 1'b0;
        throttle           = 1'b1;
        quiet_cycles       = 0;
        last_sp            = '0;
        last_meas          = '0;
        in_if.valid        = 1'b0;
        in_if.kind         = KIND_SAMPLE;
        in_if.setpoint     = '0;
        in_if.measurement  = '0;
        cfg_if.valid       = 1'b0;
        cfg_if.index       = '0;
        cfg_if.data        = '0;
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Reset settings first: zero gains give a zero drive.
        send_item(KIND_SAMPLE, 16'sd1000, -16'sd1000);
        send_item(KIND_SAMPLE, 16'h7FFF, 16'h8000);
        settle();

        apply_setting(24'sd4096, 24'sd409, -24'sd2048, 24'd100, 24'd1000, 24'd30000);
        send_item(KIND_RESTART, '0, '0);
        send_item(KIND_SAMPLE, 16'sd100, 16'sd0);
        send_item(KIND_SAMPLE, 16'sd0, 16'sd100);
        send_item(KIND_SAMPLE, 16'h7FFF, 16'h8000);
        send_item(KIND_SAMPLE, 16'h8000, 16'h7FFF);
        send_item(KIND_SAMPLE, 16'sd5, 16'sd5);
        send_item(KIND_SAMPLE, 16'sd5, 16'sd5);
        send_item(KIND_RESTART, 16'h7FFF, 16'h8000);
        send_item(KIND_SAMPLE, 16'sd0, 16'sd0);
        send_item(KIND_SAMPLE, -16'sd300, 16'sd200);
        send_item(KIND_RESTART, '0, '0);
        send_item(KIND_RESTART, '1, '1);
        send_item(KIND_SAMPLE, 16'sd1, 16'sd0);
        send_item(KIND_SAMPLE, 16'sd0, 16'sd1);
        settle();

        // Proportional term alone, with a sum of zero under a large bias.
        apply_setting(24'sd4096, 24'sd0, 24'sd0, 24'd32767, 24'd32767, 24'd32767);
        send_item(KIND_RESTART, '0, '0);
        send_item(KIND_SAMPLE, 16'sd7, 16'sd7);
        send_item(KIND_SAMPLE, 16'sd8, 16'sd7);
        send_item(KIND_SAMPLE, 16'sd6, 16'sd7);
        settle();

        for (int ph = 0; ph < PHASES; ph++) begin
            throttle = (ph != 3);
            case (ph)
                0: apply_setting(24'h7FFFFF, 24'h7FFFFF, 24'h7FFFFF,
                                 24'd32767, 24'd32767, 24'd32767);
                1: apply_setting(24'h800000, 24'h800000, 24'h800000, 24'd0, 24'd0, 24'd0);
                2: apply_setting(pick_gain(), pick_gain(), pick_gain(), 24'd0,
                                 24'd32767, 24'd32767);
                default: apply_setting(pick_gain(), pick_gain(), pick_gain(),
                                       pick_limit(), pick_limit(), pick_limit());
            endcase
            send_item(KIND_RESTART, '0, '0);
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                if (ph == 5 && n == PHASE_ITEMS / 2) begin
                    stop_items();
                end
                send_random_item();
            end
            settle();
        end
        throttle = 1'b1;

        if (tracker.mismatches == 0 && tracker.pending_drives.size() == 0) begin
            $display("pid_controller_step test passed");
        end else begin
            $display("pid_controller_step test failed");
        end
        $finish;
    end

endmodule
